FILE: design/hashed_client_table_top_defines.svh
// Assertion macros for the hashed client table.
// Used by modules that carry i_clk and i_rst_n; no other dependencies.
`ifndef HASHED_CLIENT_TABLE_TOP_DEFINES_SVH
`define HASHED_CLIENT_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define HCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define HCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/hct_pkg.sv
// Shared types, codes and defaults for the hashed client table.
// No dependencies; imported by every module of the block.
`default_nettype none

package hct_pkg;

    localparam int HCT_BUCKETS_DEF = 16;
    localparam int HCT_WAYS_DEF    = 4;

    localparam int HCT_KEY_W  = 16;
    localparam int HCT_CID_W  = 16;
    localparam int HCT_GID_W  = 8;

    // key is reduced modulo the bucket count a nibble per cycle, MSB first
    localparam int HCT_HASH_BITS  = 4;
    localparam int HCT_HASH_STEPS = HCT_KEY_W / HCT_HASH_BITS;
    localparam int HCT_DIG_W      = $clog2(HCT_HASH_STEPS);

    localparam logic [1:0] HCT_CMD_INSERT = 2'd0;
    localparam logic [1:0] HCT_CMD_LOOKUP = 2'd1;
    localparam logic [1:0] HCT_CMD_DELETE = 2'd2;

    localparam logic [1:0] HCT_ST_OK   = 2'd0;
    localparam logic [1:0] HCT_ST_MISS = 2'd1;
    localparam logic [1:0] HCT_ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [HCT_KEY_W-1:0] descriptor;
        logic [HCT_CID_W-1:0] client_id;
        logic [HCT_GID_W-1:0] group_id;
    } t_req;

    typedef struct packed {
        logic [1:0]           status;
        logic [HCT_CID_W-1:0] found_client;
        logic [HCT_GID_W-1:0] found_group;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       hash;
        logic       fill_rd;
        logic       way_clr;
        logic       slot_rd;
        logic       sh_rd;
        logic       way_inc;
        logic       ins_wr;
        logic       del_fill;
        logic       sh_wr;
        logic       take_hit;
        logic       emit;
        logic [1:0] status;
    } t_dp_ctl;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] cmd;
        logic       hash_last;
        logic       full;
        logic       way_end;
        logic       last_cmp;
        logic       shift_end;
        logic       key_hit;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: design/hct_ctrl.sv
// Sequencing state machine of the hashed client table.
// Depends on hct_pkg and hashed_client_table_top_defines.svh.
`default_nettype none
`include "hashed_client_table_top_defines.svh"

module hct_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire hct_pkg::t_dp_sts i_sts,
    output hct_pkg::t_dp_ctl      o_ctl,
    output logic                  o_busy
);
    import hct_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_HASH     = 7'b0000010,
        S_FILL     = 7'b0000100,
        S_DISPATCH = 7'b0001000,
        S_CMP      = 7'b0010000,
        S_SH_RD    = 7'b0100000,
        S_SH_WR    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ctl.status = HCT_ST_MISS;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_ctl.hash = 1'b1;
                if (i_sts.hash_last) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_ctl.fill_rd = 1'b1;
                o_ctl.way_clr = 1'b1;
                n_state       = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_sts.cmd)
                    HCT_CMD_INSERT: begin
                        o_ctl.emit = 1'b1;
                        n_state    = S_IDLE;
                        if (i_sts.full) begin
                            o_ctl.status = HCT_ST_FULL;
                        end else begin
                            o_ctl.ins_wr = 1'b1;
                            o_ctl.status = HCT_ST_OK;
                        end
                    end
                    HCT_CMD_LOOKUP, HCT_CMD_DELETE: begin
                        if (i_sts.way_end) begin
                            o_ctl.emit = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            o_ctl.slot_rd = 1'b1;
                            n_state       = S_CMP;
                        end
                    end
                    default: begin
                        // unused command: no change, reported as a miss
                        o_ctl.emit = 1'b1;
                        n_state    = S_IDLE;
                    end
                endcase
            end
            S_CMP: begin
                if (i_sts.key_hit) begin
                    o_ctl.status = HCT_ST_OK;
                    if (i_sts.cmd == HCT_CMD_LOOKUP) begin
                        o_ctl.take_hit = 1'b1;
                        o_ctl.emit     = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        o_ctl.del_fill = 1'b1;
                        if (i_sts.last_cmp) begin
                            o_ctl.emit = 1'b1;
                            n_state    = S_IDLE;
                        end else begin
                            o_ctl.sh_rd = 1'b1;
                            n_state     = S_SH_WR;
                        end
                    end
                end else if (i_sts.last_cmp) begin
                    o_ctl.emit = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    // read the next way while stepping onto it
                    o_ctl.sh_rd   = 1'b1;
                    o_ctl.way_inc = 1'b1;
                end
            end
            S_SH_RD: begin
                o_ctl.sh_rd = 1'b1;
                n_state     = S_SH_WR;
            end
            S_SH_WR: begin
                o_ctl.sh_wr   = 1'b1;
                o_ctl.way_inc = 1'b1;
                if (i_sts.shift_end) begin
                    o_ctl.emit   = 1'b1;
                    o_ctl.status = HCT_ST_OK;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_SH_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `HCT_ASSERT_NEXT(a_emit_then_idle, o_ctl.emit, r_state == S_IDLE, "emit did not end request")
    `HCT_ASSERT_NEXT(a_accept_to_hash, i_start && !o_busy, r_state == S_HASH, "accept lost")
    `HCT_ASSERT_NOW(a_cmp_within_fill, r_state == S_CMP, !i_sts.way_end, "compare past fill")

endmodule

`default_nettype wire

FILE: design/hct_dpath.sv
// Datapath of the hashed client table: hash unit, fill and slot memories, result.
// Depends on hct_pkg.
`default_nettype none

module hct_dpath #(
    parameter int BUCKETS = hct_pkg::HCT_BUCKETS_DEF,
    parameter int WAYS    = hct_pkg::HCT_WAYS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire hct_pkg::t_req    i_req,
    input  wire hct_pkg::t_dp_ctl i_ctl,
    output hct_pkg::t_dp_sts      o_sts,
    output hct_pkg::t_rsp         o_rsp,
    output logic                  o_done
);
    import hct_pkg::*;

    localparam int SLOTS  = BUCKETS * WAYS;
    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int ACC_W  = BKT_W + 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(WAYS + 1);
    localparam int CNTX_W = CNT_W + 1;

    typedef struct packed {
        logic [HCT_KEY_W-1:0] key;
        logic [HCT_CID_W-1:0] client;
        logic [HCT_GID_W-1:0] group;
    } t_slot;

    t_slot                r_slot_mem [SLOTS];
    logic [CNT_W-1:0]     r_fill_mem [BUCKETS];
    logic [BUCKETS-1:0]   r_bkt_vld;

    t_req                 r_req;
    logic [HCT_KEY_W-1:0] r_ksh;
    logic [HCT_DIG_W-1:0] r_dig;
    logic [BKT_W-1:0]     r_rem;
    logic [BKT_W-1:0]     n_rem;
    logic [SLOT_W-1:0]    r_base;
    logic [CNT_W-1:0]     r_fill_q;
    logic                 r_bv_q;
    logic [CNT_W-1:0]     r_way;
    t_slot                r_slot_q;
    logic [1:0]           r_status;
    logic [HCT_CID_W-1:0] r_fc;
    logic [HCT_GID_W-1:0] r_fg;
    logic                 r_done;

    logic [ACC_W-1:0]     v_acc;
    logic [CNT_W-1:0]     v_fill;
    logic [SLOT_W-1:0]    v_way_addr;
    logic [SLOT_W-1:0]    v_rd_addr;
    logic [SLOT_W-1:0]    v_wr_addr;
    t_slot                v_wr_data;

    // one nibble of restoring modulo reduction
    always_comb begin
        n_rem = r_rem;
        v_acc = '0;
        for (int i = 0; i < HCT_HASH_BITS; i++) begin
            v_acc = {n_rem, r_ksh[HCT_KEY_W-1-i]};
            if (v_acc >= ACC_W'(BUCKETS)) begin
                v_acc = v_acc - ACC_W'(BUCKETS);
            end
            n_rem = v_acc[BKT_W-1:0];
        end
    end

    // a bucket never written counts as empty
    assign v_fill     = r_bv_q ? r_fill_q : '0;
    assign v_way_addr = r_base + SLOT_W'(r_way);
    assign v_rd_addr  = i_ctl.sh_rd ? v_way_addr + SLOT_W'(1) : v_way_addr;
    assign v_wr_addr  = i_ctl.ins_wr ? r_base + SLOT_W'(v_fill) : v_way_addr;

    always_comb begin
        if (i_ctl.ins_wr) begin
            v_wr_data.key    = r_req.descriptor;
            v_wr_data.client = r_req.client_id;
            v_wr_data.group  = r_req.group_id;
        end else begin
            v_wr_data = r_slot_q;
        end
    end

    always_comb begin
        o_sts.cmd       = r_req.cmd;
        o_sts.hash_last = (r_dig == HCT_DIG_W'(HCT_HASH_STEPS - 1));
        o_sts.full      = (v_fill == CNT_W'(WAYS));
        o_sts.way_end   = (r_way >= v_fill);
        o_sts.last_cmp  = ((CNTX_W'(r_way) + CNTX_W'(1)) >= CNTX_W'(v_fill));
        o_sts.shift_end = ((CNTX_W'(r_way) + CNTX_W'(2)) >= CNTX_W'(v_fill));
        o_sts.key_hit   = (r_slot_q.key == r_req.descriptor);
    end

    // slot memory: one read, one write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_wr || i_ctl.sh_wr) begin
            r_slot_mem[v_wr_addr] <= v_wr_data;
        end
        if (i_ctl.slot_rd || i_ctl.sh_rd) begin
            r_slot_q <= r_slot_mem[v_rd_addr];
        end
    end

    // fill count memory, one entry per bucket
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_wr) begin
            r_fill_mem[r_rem] <= v_fill + CNT_W'(1);
        end else if (i_ctl.del_fill) begin
            r_fill_mem[r_rem] <= v_fill - CNT_W'(1);
        end
        if (i_ctl.fill_rd) begin
            r_fill_q <= r_fill_mem[r_rem];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bkt_vld <= '0;
            r_bv_q    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            if (i_ctl.ins_wr) begin
                r_bkt_vld[r_rem] <= 1'b1;
            end
            if (i_ctl.fill_rd) begin
                r_bv_q <= r_bkt_vld[r_rem];
            end
            r_done <= i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req <= i_req;
            r_ksh <= i_req.descriptor;
            r_dig <= '0;
            r_rem <= '0;
            r_fc  <= '0;
            r_fg  <= '0;
        end else if (i_ctl.hash) begin
            r_ksh <= r_ksh << HCT_HASH_BITS;
            r_dig <= r_dig + HCT_DIG_W'(1);
            r_rem <= n_rem;
        end
        if (i_ctl.fill_rd) begin
            r_base <= SLOT_W'(r_rem) * SLOT_W'(WAYS);
        end
        if (i_ctl.way_clr) begin
            r_way <= '0;
        end else if (i_ctl.way_inc) begin
            r_way <= r_way + CNT_W'(1);
        end
        if (i_ctl.take_hit) begin
            r_fc <= r_slot_q.client;
            r_fg <= r_slot_q.group;
        end
        if (i_ctl.emit) begin
            r_status <= i_ctl.status;
        end
    end

    assign o_rsp.status       = r_status;
    assign o_rsp.found_client = r_fc;
    assign o_rsp.found_group  = r_fg;
    assign o_done             = r_done;

endmodule

`default_nettype wire

FILE: design/hashed_client_table_top.sv
// Top level of the hashed client table: controller plus datapath.
// Depends on hct_pkg, hct_ctrl and hct_dpath.
//
//   port        dir  kind       notes
//   start/busy  in   handshake  request taken when start && !busy
//   i_req       in   payload    cmd, descriptor, client_id, group_id
//   o_done      out  strobe     one cycle per result, cannot be held off
//   o_rsp       out  payload    status, found_client, found_group
//
// Sequence: the key is reduced modulo BUCKETS a nibble per cycle, then the
//   bucket's fill count is read and the command dispatched; an insert emits
//   its result from the dispatch state. Lookup/delete compare the ways walked
//   one at a time through the single slot-memory read port, and a delete that
//   shifts entries down on compaction alternates shift reads and shift writes.
// Reset: synchronous, active low; clears the state machine, the per-bucket
//   valid flags and the result strobe. No clearing pass is needed.
// busy drops in the result cycle, so the next request may follow at once.
`default_nettype none

module hashed_client_table_top #(
    parameter int BUCKETS = hct_pkg::HCT_BUCKETS_DEF,
    parameter int WAYS    = hct_pkg::HCT_WAYS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire hct_pkg::t_req i_req,
    output logic               o_done,
    output hct_pkg::t_rsp      o_rsp
);
    import hct_pkg::*;

    t_dp_ctl w_ctl;
    t_dp_sts w_sts;

    // sequencing only; all storage lives in the datapath
    hct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl),
        .o_busy  (busy)
    );

    // hash unit, fill counts, slot memory and result registers
    hct_dpath #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_rsp   (o_rsp),
        .o_done  (o_done)
    );

endmodule

`default_nettype wire

FILE: tb/sv/hashed_client_table_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for hashed_client_table_top: directed and random requests.
// Depends on hct_pkg and the hashed client table RTL; holds its own table model.

module hashed_client_table_top_test;

    import hct_pkg::*;

    localparam int BUCKETS = HCT_BUCKETS_DEF;
    localparam int WAYS    = HCT_WAYS_DEF;
    localparam int SLOTS   = BUCKETS * WAYS;

    // cmd value with no operation behind it; the block answers with a miss
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int IDLE_LIMIT  = 2000;  // cycles with no request and no result
    localparam int TAIL_CYCLES = 40;    // longest delete with full compaction, plus margin
    localparam int HOT_KEYS    = 12;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  i_req   = '0;
    logic  busy;
    logic  o_done;
    t_rsp  o_rsp;

    // table model: one copy of the bucket slots, prefix-valid per bucket
    logic                 tbl_valid  [SLOTS];
    logic [HCT_KEY_W-1:0] tbl_key    [SLOTS];
    logic [HCT_CID_W-1:0] tbl_client [SLOTS];
    logic [HCT_GID_W-1:0] tbl_group  [SLOTS];

    t_rsp pending_rsp[$];   // responses owed by the block, oldest first
    int   mismatches = 0;
    int   idle_cycles = 0;

    // sender pacing
    int   burst_left = 0;
    bit   gaps_on    = 1'b1;

    logic [HCT_KEY_W-1:0] hot_keys [HOT_KEYS];

    hashed_client_table_top #(
        .BUCKETS(BUCKETS),
        .WAYS   (WAYS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Table model. Applies one request to the model state and returns
    // the response the block must give for it.
    // ------------------------------------------------------------------
    function automatic t_rsp apply_table_op(input t_req r);
        t_rsp rsp;
        int   base;
        int   fill;
        int   hit;
        rsp  = '{status: HCT_ST_MISS, found_client: '0, found_group: '0};
        base = (int'(r.descriptor) % BUCKETS) * WAYS;
        // valid entries always sit at the front of the bucket
        fill = 0;
        while (fill < WAYS && tbl_valid[base + fill])
            fill++;
        // oldest entry with the key, WAYS when absent
        hit = WAYS;
        for (int w = 0; w < fill; w++) begin
            if (hit == WAYS && tbl_key[base + w] == r.descriptor)
                hit = w;
        end
        case (r.cmd)
            HCT_CMD_INSERT: begin
                if (fill >= WAYS) begin
                    rsp.status = HCT_ST_FULL;
                end else begin
                    tbl_valid[base + fill]  = 1'b1;
                    tbl_key[base + fill]    = r.descriptor;
                    tbl_client[base + fill] = r.client_id;
                    tbl_group[base + fill]  = r.group_id;
                    rsp.status = HCT_ST_OK;
                end
            end
            HCT_CMD_LOOKUP: begin
                if (hit < WAYS) begin
                    rsp.status       = HCT_ST_OK;
                    rsp.found_client = tbl_client[base + hit];
                    rsp.found_group  = tbl_group[base + hit];
                end
            end
            HCT_CMD_DELETE: begin
                if (hit < WAYS) begin
                    // compact: later entries move down one way, order kept
                    for (int w = hit; w + 1 < fill; w++) begin
                        tbl_key[base + w]    = tbl_key[base + w + 1];
                        tbl_client[base + w] = tbl_client[base + w + 1];
                        tbl_group[base + w]  = tbl_group[base + w + 1];
                    end
                    tbl_valid[base + fill - 1] = 1'b0;
                    rsp.status = HCT_ST_OK;
                end
            end
            default: ;  // unused command: no change, miss
        endcase
        return rsp;
    endfunction

    function automatic t_req mk_req(input logic [1:0] cmd, input logic [15:0] key,
                                    input logic [15:0] cid, input logic [7:0] gid);
        t_req r;
        r.cmd        = cmd;
        r.descriptor = key;
        r.client_id  = cid;
        r.group_id   = gid;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender. Called just after a rising edge; holds the request until it
    // is taken, books the owed response, then applies burst/gap pacing.
    // ------------------------------------------------------------------
    task automatic send_req(input t_req r);
        int gap;
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_rsp.push_back(apply_table_op(r));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if (gaps_on) begin
                // gap length spans the whole request latency so pauses land
                // on hashing, fill read, compare and shift cycles alike
                gap = $urandom_range(1, 24);
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 19);
        end
    endtask

    // Sender holds off until the block owes nothing.
    task automatic drain_pending();
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Response checker. o_done is a one-cycle strobe; sampled at the edge
    // that ends its cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_rsp.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected response, expected none, actual %h", $time, o_rsp);
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.status !== want.status) begin
                    mismatches++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, o_rsp.status);
                end
                if (o_rsp.found_client !== want.found_client) begin
                    mismatches++;
                    $display("%0t: found_client mismatch, expected %h, actual %h",
                             $time, want.found_client, o_rsp.found_client);
                end
                if (o_rsp.found_group !== want.found_group) begin
                    mismatches++;
                    $display("%0t: found_group mismatch, expected %h, actual %h",
                             $time, want.found_group, o_rsp.found_group);
                end
            end
        end
    end

    // Watchdog: a request taken or a response given resets the count.
    always @(posedge i_clk) begin
        if ((start && !busy) === 1'b1 || o_done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired with %0d responses owed", $time, pending_rsp.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Nothing valid after reset: lookups and deletes all miss.
    task automatic test_empty_table();
        send_req(mk_req(HCT_CMD_LOOKUP, 16'h0000, 16'h0000, 8'h00));
        send_req(mk_req(HCT_CMD_DELETE, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_req(mk_req(HCT_CMD_LOOKUP, 16'h1234, 16'h5678, 8'h9A));
    endtask

    // Bucket 0 filled to all ways, including a duplicate key; one more is refused.
    task automatic test_bucket_fill();
        send_req(mk_req(HCT_CMD_INSERT, 16'h0000, 16'hFFFF, 8'hFF));
        send_req(mk_req(HCT_CMD_INSERT, 16'h0010, 16'h0000, 8'h00));
        send_req(mk_req(HCT_CMD_INSERT, 16'hFFF0, 16'h1234, 8'h5A));
        send_req(mk_req(HCT_CMD_INSERT, 16'h0010, 16'hBEEF, 8'hA5));
        send_req(mk_req(HCT_CMD_INSERT, 16'h0020, 16'h7777, 8'h33));
    endtask

    // Duplicates: lookup and delete act on the oldest copy.
    task automatic test_duplicate_keys();
        send_req(mk_req(HCT_CMD_LOOKUP, 16'h0010, 16'h0000, 8'h00));
        send_req(mk_req(HCT_CMD_DELETE, 16'h0010, 16'h0000, 8'h00));
        send_req(mk_req(HCT_CMD_LOOKUP, 16'h0010, 16'h0000, 8'h00));
    endtask

    // Deleting the head keeps the rest of the chain.
    task automatic test_head_delete();
        send_req(mk_req(HCT_CMD_DELETE, 16'h0000, 16'h0000, 8'h00));
        send_req(mk_req(HCT_CMD_LOOKUP, 16'hFFF0, 16'h0000, 8'h00));
        send_req(mk_req(HCT_CMD_LOOKUP, 16'h0000, 16'h0000, 8'h00));
        send_req(mk_req(HCT_CMD_LOOKUP, 16'h0010, 16'h0000, 8'h00));
    endtask

    // Top bucket, and a missing key in an occupied bucket.
    task automatic test_edge_keys();
        send_req(mk_req(HCT_CMD_INSERT, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_req(mk_req(HCT_CMD_LOOKUP, 16'hFFFF, 16'h0000, 8'h00));
        send_req(mk_req(HCT_CMD_DELETE, 16'h000F, 16'h0000, 8'h00));
    endtask

    // Unused command: ignored, answered with a miss.
    task automatic test_unused_cmd();
        send_req(mk_req(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_req(mk_req(HCT_CMD_LOOKUP, 16'hFFFF, 16'h0000, 8'h00));
    endtask

    // ------------------------------------------------------------------
    // Random traffic. Most keys come from a small hot set over three
    // buckets, so buckets fill, duplicates pile up and deletes compact;
    // the rest are wide random keys and the odd unused command.
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input int n_reqs, input bit with_gaps);
        logic [3:0]  bkt [3];
        logic [1:0]  cmd;
        logic [15:0] key;
        int          pick;
        gaps_on = with_gaps;
        foreach (bkt[i])
            bkt[i] = 4'($urandom_range(0, BUCKETS - 1));
        foreach (hot_keys[k])
            hot_keys[k] = {12'($urandom_range(0, 4095)), bkt[k / 4]};
        repeat (n_reqs) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                cmd = HCT_CMD_INSERT;
            else if (pick < 70)
                cmd = HCT_CMD_LOOKUP;
            else if (pick < 96)
                cmd = HCT_CMD_DELETE;
            else
                cmd = CMD_UNUSED;
            if ($urandom_range(0, 99) < 75)
                key = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
            else
                key = 16'($urandom);
            send_req(mk_req(cmd, key, 16'($urandom), 8'($urandom)));
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        foreach (tbl_valid[s]) begin
            tbl_valid[s]  = 1'b0;
            tbl_key[s]    = '0;
            tbl_client[s] = '0;
            tbl_group[s]  = '0;
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_bucket_fill();
        test_duplicate_keys();
        test_head_delete();
        test_edge_keys();
        test_unused_cmd();

        test_random_traffic(208, 1'b1);
        test_random_traffic(208, 1'b1);
        // sender holds off until every owed response is back
        drain_pending();
        test_random_traffic(208, 1'b0);
        test_random_traffic(208, 1'b1);

        drain_pending();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
